// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/xtea_pkg.sv =====
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int WORD_W         = 32;
  localparam int RC_W           = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_ROUNDS_DEF = 64;

  localparam logic [WORD_W-1:0] DELTA    = 32'h9E3779B9;
  localparam int                SUM_SHIFT = 11;
  localparam int                MIX_SHL   = 4;
  localparam int                MIX_SHR   = 5;

  localparam logic [RC_W-1:0] RC_RESET = 7'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd4;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
    return ((v << MIX_SHL) ^ (v >> MIX_SHR)) + v;
  endfunction

  // one half-round term: mix of the other half xored with sum plus key
  function automatic logic [WORD_W-1:0] half_term(input logic [WORD_W-1:0] v,
                                                  input logic [WORD_W-1:0] s,
                                                  input logic [WORD_W-1:0] k);
    return mix(v) ^ (s + k);
  endfunction

  function automatic logic [WORD_W-1:0] key_pick(input logic [1:0]        sel,
                                                 input logic [WORD_W-1:0] k0,
                                                 input logic [WORD_W-1:0] k1,
                                                 input logic [WORD_W-1:0] k2,
                                                 input logic [WORD_W-1:0] k3);
    logic [WORD_W-1:0] k;
    unique case (sel)
      2'd0: k = k0;
      2'd1: k = k1;
      2'd2: k = k2;
      2'd3: k = k3;
      default: k = k0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/xtea_block_cipher.sv =====
// XTEA block cipher, one 64-bit block per item, encrypt or decrypt chosen per item by
// in_command. The rounds are fully unrolled into 2*MAX_ROUNDS register stages, one per
// half-round, plus an entry stage, so it takes one item every cycle while the skid
// register is empty; each item passes all stages whatever round_count holds; stages
// beyond the programmed count pass the item along untouched, and a count above
// MAX_ROUNDS runs MAX_ROUNDS rounds. A skid register behind the output register keeps
// the input open for one more item while a result waits. Keys are read live by the
// stages, the round count at entry, so write them only while the block is empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xtea_block_cipher #(
  parameter int MAX_ROUNDS = xtea_pkg::MAX_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [xtea_pkg::WORD_W-1:0]    in_block_first,
  input  logic [xtea_pkg::WORD_W-1:0]    in_block_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [xtea_pkg::WORD_W-1:0]    out_result_first,
  output logic [xtea_pkg::WORD_W-1:0]    out_result_second
);

  localparam int NS = 2 * MAX_ROUNDS;
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int W  = xtea_pkg::WORD_W;

  typedef struct packed {
    logic          dec;
    logic [RW-1:0] rounds;
    logic [W-1:0]  sum;
    logic [W-1:0]  y;
    logic [W-1:0]  z;
  } item_t;

  // configuration
  logic [W-1:0]              key0_r, key1_r, key2_r, key3_r;
  logic [xtea_pkg::RC_W-1:0] round_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r        <= '0;
      key1_r        <= '0;
      key2_r        <= '0;
      key3_r        <= '0;
      round_count_r <= xtea_pkg::RC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xtea_pkg::REG_KEY0:   key0_r <= cfg_data;
        xtea_pkg::REG_KEY1:   key1_r <= cfg_data;
        xtea_pkg::REG_KEY2:   key2_r <= cfg_data;
        xtea_pkg::REG_KEY3:   key3_r <= cfg_data;
        xtea_pkg::REG_ROUNDS: round_count_r <= cfg_data[xtea_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          pipe_en;
  logic [NS:0]   vld_r;
  item_t         pipe_r  [0:NS];
  item_t         stg_nxt [0:NS-1];
  item_t         entry_nxt;
  logic [RW-1:0] n_sat;
  logic          skid_valid_r;
  logic          out_valid_r;
  logic [W-1:0]  skid_y_r, skid_z_r, out_y_r, out_z_r;

  assign pipe_en  = !skid_valid_r;
  assign in_ready = pipe_en;

  always_comb begin
    if (32'(round_count_r) > 32'(MAX_ROUNDS)) begin
      n_sat = RW'(MAX_ROUNDS);
    end else begin
      n_sat = RW'(round_count_r);
    end
    entry_nxt.dec    = in_command;
    entry_nxt.rounds = n_sat;
    entry_nxt.y      = in_block_first;
    entry_nxt.z      = in_block_second;
    // decryption starts from delta times the round count
    if (in_command) begin
      entry_nxt.sum = W'(xtea_pkg::DELTA * W'(n_sat));
    end else begin
      entry_nxt.sum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pipe_r[0] <= entry_nxt;
    end
  end

  for (genvar h = 0; h < NS; h++) begin : g_stage
    logic         act;
    logic [1:0]   sum_sh;
    logic [W-1:0] k_lo, k_hi;

    assign act    = pipe_r[h].rounds > RW'(h / 2);
    assign sum_sh = pipe_r[h].sum[xtea_pkg::SUM_SHIFT +: 2];
    assign k_lo   = xtea_pkg::key_pick(pipe_r[h].sum[1:0], key0_r, key1_r, key2_r, key3_r);
    assign k_hi   = xtea_pkg::key_pick(sum_sh, key0_r, key1_r, key2_r, key3_r);

    if (h % 2 == 0) begin : g_first_half
      // encrypt updates y and steps sum up; decrypt updates z and steps sum down
      always_comb begin
        stg_nxt[h] = pipe_r[h];
        if (act) begin
          if (!pipe_r[h].dec) begin
            stg_nxt[h].y   = pipe_r[h].y
                             + xtea_pkg::half_term(pipe_r[h].z, pipe_r[h].sum, k_lo);
            stg_nxt[h].sum = pipe_r[h].sum + xtea_pkg::DELTA;
          end else begin
            stg_nxt[h].z   = pipe_r[h].z
                             - xtea_pkg::half_term(pipe_r[h].y, pipe_r[h].sum, k_hi);
            stg_nxt[h].sum = pipe_r[h].sum - xtea_pkg::DELTA;
          end
        end
      end
    end else begin : g_second_half
      always_comb begin
        stg_nxt[h] = pipe_r[h];
        if (act) begin
          if (!pipe_r[h].dec) begin
            stg_nxt[h].z = pipe_r[h].z
                           + xtea_pkg::half_term(pipe_r[h].y, pipe_r[h].sum, k_hi);
          end else begin
            stg_nxt[h].y = pipe_r[h].y
                           - xtea_pkg::half_term(pipe_r[h].z, pipe_r[h].sum, k_lo);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        pipe_r[h + 1] <= stg_nxt[h];
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || vld_r[NS];
      skid_valid_r <= 1'b0;
    end else if (pipe_en && vld_r[NS]) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_y_r <= skid_y_r;
        out_z_r <= skid_z_r;
      end else begin
        out_y_r <= pipe_r[NS].y;
        out_z_r <= pipe_r[NS].z;
      end
    end else if (pipe_en && vld_r[NS]) begin
      skid_y_r <= pipe_r[NS].y;
      skid_z_r <= pipe_r[NS].z;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_first  = out_y_r;
  assign out_result_second = out_z_r;

  `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `ASSERT_IMPL(a_skid_blocks_input, clk, rst_n, skid_valid_r, !in_ready)
  `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, pipe_en && vld_r[NS] && out_valid_r && !out_ready, skid_valid_r)
  `ASSERT_NEXT(a_pipe_holds, clk, rst_n, !pipe_en, $stable(vld_r))

endmodule
